### design/bwrle_pkg.sv
// Shared types and codes for the boolean row combiner and run-length encoder.
package bwrle_pkg;

   localparam int VALUE_W = 13;
   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   localparam logic [1:0] KIND_FIRST = 2'd0;
   localparam logic [1:0] KIND_RUN   = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [1:0] MODE_AND  = 2'd0;
   localparam logic [1:0] MODE_OR   = 2'd1;
   localparam logic [1:0] MODE_XOR  = 2'd2;
   localparam logic [1:0] MODE_PASS = 2'd3;

   localparam int WORDS_MAX = 3;

   typedef struct packed {
      logic pixel_a;
      logic pixel_b;
      logic row_end;
   } req_type;

   typedef struct packed {
      logic [1:0]         word_kind;
      logic [VALUE_W-1:0] word_value;
      logic               last_word;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    word2;
      rsp_type    word1;
      rsp_type    word0;
   } enc_words_type;

endpackage

### design/bwrle_encode.sv
// Pixel combiner and run-length state: turns one pixel pair into up to three words.
module bwrle_encode #(
   parameter logic [bwrle_pkg::VALUE_W-1:0] RUN_CAP = 13'd4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  bwrle_pkg::req_type       req_data,
   input  logic [1:0]               mode,
   output bwrle_pkg::enc_words_type words
);

   logic                            prev_ff, prev_in;
   logic [bwrle_pkg::VALUE_W-1:0]   run_ff, run_in;
   logic                            started_ff, started_in;
   logic                            pix;
   logic                            head;
   logic [bwrle_pkg::VALUE_W-1:0]   run_next;
   bwrle_pkg::rsp_type              w_head, w_run, w_end;

   always_comb begin
      case (mode)
         bwrle_pkg::MODE_AND: pix = req_data.pixel_a & req_data.pixel_b;
         bwrle_pkg::MODE_OR:  pix = req_data.pixel_a | req_data.pixel_b;
         bwrle_pkg::MODE_XOR: pix = req_data.pixel_a ^ req_data.pixel_b;
         default:             pix = req_data.pixel_a;
      endcase
   end

   always_comb begin
      head = !started_ff || (pix != prev_ff);
      if (head) begin
         run_next = bwrle_pkg::VALUE_W'(1);
      end else if (run_ff < RUN_CAP) begin
         run_next = run_ff + bwrle_pkg::VALUE_W'(1);
      end else begin
         run_next = run_ff;
      end

      w_head.word_kind  = started_ff ? bwrle_pkg::KIND_RUN : bwrle_pkg::KIND_FIRST;
      w_head.word_value = started_ff ? run_ff : {{(bwrle_pkg::VALUE_W-1){1'b0}}, pix};
      w_head.last_word  = 1'b0;

      w_run.word_kind  = bwrle_pkg::KIND_RUN;
      w_run.word_value = run_next;
      w_run.last_word  = 1'b0;

      w_end.word_kind  = bwrle_pkg::KIND_END;
      w_end.word_value = '0;
      w_end.last_word  = 1'b1;

      words.count = {1'b0, head} + {req_data.row_end, 1'b0};
      if (head) begin
         words.word0 = w_head;
         words.word1 = w_run;
         words.word2 = w_end;
      end else begin
         words.word0 = w_run;
         words.word1 = w_end;
         words.word2 = w_end;
      end
      if (!accept) begin
         words.count = 2'd0;
      end
   end

   always_comb begin
      prev_in    = prev_ff;
      run_in     = run_ff;
      started_in = started_ff;
      if (accept) begin
         prev_in = pix;
         if (req_data.row_end) begin
            run_in     = '0;
            started_in = 1'b0;
         end else begin
            run_in     = run_next;
            started_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= 1'b0;
         run_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         prev_ff    <= prev_in;
         run_ff     <= run_in;
         started_ff <= started_in;
      end
   end

endmodule

### design/bwrle_outq.sv
// Four-word result queue: takes up to three words a cycle, hands out one while rsp_ready is high.
module bwrle_outq (
   input  logic                     clock,
   input  logic                     reset,
   input  bwrle_pkg::enc_words_type words,
   output logic                     space,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bwrle_pkg::rsp_type       rsp_data
);

   bwrle_pkg::rsp_type  mem_ff [4];
   bwrle_pkg::rsp_type  wdata [bwrle_pkg::WORDS_MAX];
   logic [1:0]          wr_ptr_ff, wr_ptr_in;
   logic [1:0]          rd_ptr_ff, rd_ptr_in;
   logic [2:0]          count_ff, count_in;
   logic                pop;

   assign wdata[0] = words.word0;
   assign wdata[1] = words.word1;
   assign wdata[2] = words.word2;

   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign space     = (count_ff < 3'd2);
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + words.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, words.count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < bwrle_pkg::WORDS_MAX; i++) begin
         if (2'(i) < words.count) begin
            mem_ff[2'(wr_ptr_ff + 2'(i))] <= wdata[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/bw_boolean_combine_rle_encoder.sv
// Top level of the boolean row combiner and run-length encoder.
// One pixel pair is taken per clock while req_ready is high. Each transaction is combined
// and encoded in the accepting cycle into a four-word result queue, whose registers feed
// rsp_. The result channel moves one word per cycle while rsp_ready is high; a pixel
// yields up to three words (first pixel, colour change, row end), and req_ready drops
// while the queue holds two or more words. Rows whose pixels mostly continue a run
// stream at one pixel per clock while rsp_ready is high. csr_ready is always high; a
// new combine_mode applies from the next pixel. Runs saturate at MAX_WIDTH (at most 8191).
module bw_boolean_combine_rle_encoder #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bwrle_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bwrle_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_data
);

   localparam int RunCapInt = (MAX_WIDTH > int'(bwrle_pkg::VALUE_MAX)) ?
                              int'(bwrle_pkg::VALUE_MAX) : MAX_WIDTH;
   localparam logic [bwrle_pkg::VALUE_W-1:0] RunCap = bwrle_pkg::VALUE_W'(RunCapInt);

   logic [1:0]               combine_mode_ff, combine_mode_in;
   logic                     accept;
   logic                     space;
   bwrle_pkg::enc_words_type words;

   assign csr_ready = 1'b1;
   assign req_ready = space;
   assign accept    = req_valid && space;

   always_comb begin
      combine_mode_in = combine_mode_ff;
      if (csr_valid && csr_ready) begin
         combine_mode_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         combine_mode_ff <= bwrle_pkg::MODE_PASS;
      end else begin
         combine_mode_ff <= combine_mode_in;
      end
   end

   bwrle_encode #(
      .RUN_CAP (RunCap)
   ) u_encode (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .mode     (combine_mode_ff),
      .words    (words)
   );

   bwrle_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .words     (words),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### design/bwrle_checker.sv
// Port-level assertions for the encoder, bound to the top level.
module bwrle_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input bwrle_pkg::rsp_type  rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_kind == bwrle_pkg::KIND_END)))
      else $error("last_word and end marker disagree");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.word_kind == bwrle_pkg::KIND_END |-> rsp_data.word_value == '0)
      else $error("end marker carries a value");

   a_first_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.word_kind == bwrle_pkg::KIND_FIRST
         |-> rsp_data.word_value[bwrle_pkg::VALUE_W-1:1] == '0)
      else $error("first pixel word wider than one bit");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind bw_boolean_combine_rle_encoder bwrle_checker u_bwrle_checker (.*);

### bench/bw_boolean_combine_rle_encoder_tb.sv
// Self-checking testbench for the boolean row combiner and run-length encoder.
module bw_boolean_combine_rle_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH = 4096;
   localparam int RUN_CAP   = (MAX_WIDTH > int'(bwrle_pkg::VALUE_MAX)) ?
                              int'(bwrle_pkg::VALUE_MAX) : MAX_WIDTH;
   localparam int LIMIT     = 200_000;
   localparam int HOLD_LEN  = 64;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   bwrle_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   bwrle_pkg::rsp_type rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_data  = bwrle_pkg::MODE_PASS;

   bwrle_pkg::req_type           pixel_fifo[$];
   bwrle_pkg::rsp_type           due_words[$];
   logic [1:0]                   combine_sel = bwrle_pkg::MODE_PASS;
   logic                         last_pix    = 1'b0;
   logic                         row_open    = 1'b0;
   logic [bwrle_pkg::VALUE_W-1:0] run_len    = '0;
   int                           send_idle   = 0;
   int                           recv_stall  = 0;
   bit                           hold_req    = 1'b0;
   bit                           hold_done   = 1'b0;
   int                           hold_cnt    = 0;
   int                           errors      = 0;
   int                           cycles      = 0;

   bw_boolean_combine_rle_encoder #(.MAX_WIDTH(MAX_WIDTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   function automatic void push_word(logic [1:0] kind,
                                     logic [bwrle_pkg::VALUE_W-1:0] value, logic last);
      bwrle_pkg::rsp_type w;
      w.word_kind  = kind;
      w.word_value = value;
      w.last_word  = last;
      due_words.push_back(w);
   endfunction

   function automatic void encode_pixel(bwrle_pkg::req_type px);
      logic pix;
      case (combine_sel)
         bwrle_pkg::MODE_AND: pix = px.pixel_a & px.pixel_b;
         bwrle_pkg::MODE_OR:  pix = px.pixel_a | px.pixel_b;
         bwrle_pkg::MODE_XOR: pix = px.pixel_a ^ px.pixel_b;
         default:             pix = px.pixel_a;
      endcase
      if (!row_open) begin
         push_word(bwrle_pkg::KIND_FIRST, bwrle_pkg::VALUE_W'(pix), 1'b0);
         run_len  = bwrle_pkg::VALUE_W'(1);
         row_open = 1'b1;
      end else if (pix != last_pix) begin
         push_word(bwrle_pkg::KIND_RUN, run_len, 1'b0);
         run_len = bwrle_pkg::VALUE_W'(1);
      end else if (run_len < RUN_CAP) begin
         run_len = run_len + 1'b1;
      end
      last_pix = pix;
      if (px.row_end) begin
         push_word(bwrle_pkg::KIND_RUN, run_len, 1'b0);
         push_word(bwrle_pkg::KIND_END, '0, 1'b1);
         row_open = 1'b0;
         run_len  = '0;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) encode_pixel(req_data);
         if (!req_valid || req_ready) begin
            if (pixel_fifo.size() != 0 && $urandom_range(99) >= send_idle) begin
               req_data  <= pixel_fifo.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         hold_cnt++;
         if (hold_cnt == HOLD_LEN) hold_done = 1'b1;
      end
   end

   // monitor and receiver back-pressure
   always @(posedge clock) begin
      bwrle_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_words.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected word: kind=%0d value=%0d last=%0b",
                        rsp_data.word_kind, rsp_data.word_value, rsp_data.last_word);
         end else begin
            want = due_words.pop_front();
            if (rsp_data.word_kind !== want.word_kind ||
                rsp_data.word_value !== want.word_value ||
                rsp_data.last_word !== want.last_word) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch (kind/value/last): expected %0d/%0d/%0b, got %0d/%0d/%0b",
                           want.word_kind, want.word_value, want.last_word,
                           rsp_data.word_kind, rsp_data.word_value, rsp_data.last_word);
            end
         end
      end
      if (hold_req && !hold_done) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic add_pixel(bit a, bit b, bit last);
      bwrle_pkg::req_type px;
      px.pixel_a = a;
      px.pixel_b = b;
      px.row_end = last;
      pixel_fifo.push_back(px);
   endtask

   // last pixel never ends its row, so the next mode change lands mid-row
   task automatic add_random_rows(int count);
      bit a, b;
      a = 1'($urandom_range(1));
      b = 1'($urandom_range(1));
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 35) a = ~a;
         if ($urandom_range(99) < 35) b = ~b;
         add_pixel(a, b, i != count - 1 && $urandom_range(99) < 15);
      end
   endtask

   task automatic drain();
      while (pixel_fifo.size() != 0 || req_valid || due_words.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_mode(logic [1:0] m);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid   <= 1'b0;
      combine_sel = m;
   endtask

   task automatic run_phase(logic [1:0] m, int sidle, int rstall, int count, bit hold);
      write_mode(m);
      @(negedge clock);
      send_idle  = sidle;
      recv_stall = rstall;
      hold_req   = hold;
      add_random_rows(count);
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // one-pixel rows, every input pair
      add_pixel(1'b0, 1'b0, 1'b1);
      add_pixel(1'b1, 1'b0, 1'b1);
      add_pixel(1'b0, 1'b1, 1'b1);
      add_pixel(1'b1, 1'b1, 1'b1);
      // colour changes between pixels, with one repeat
      add_pixel(1'b1, 1'b0, 1'b0);
      add_pixel(1'b0, 1'b1, 1'b0);
      add_pixel(1'b1, 1'b1, 1'b0);
      add_pixel(1'b1, 1'b0, 1'b0);
      add_pixel(1'b0, 1'b0, 1'b1);
      // one long run
      for (int i = 0; i < 100; i++) add_pixel(1'b1, i[0], 1'b0);
      add_pixel(1'b0, 1'b1, 1'b0);
      add_pixel(1'b0, 1'b0, 1'b1);
      // row left open across the first mode change
      add_pixel(1'b1, 1'b1, 1'b0);
      add_pixel(1'b1, 1'b0, 1'b0);
      drain();

      run_phase(bwrle_pkg::MODE_AND,  0,  0,  80, 1'b0);
      run_phase(bwrle_pkg::MODE_OR,   74, 0,  80, 1'b0);
      run_phase(bwrle_pkg::MODE_XOR,  0,  74, 80, 1'b0);
      run_phase(bwrle_pkg::MODE_PASS, 30, 30, 80, 1'b0);
      run_phase(bwrle_pkg::MODE_AND,  0,  0,  80, 1'b1);

      repeat (20) @(negedge clock);
      if (errors == 0 && due_words.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
design/bwrle_pkg.sv
design/bwrle_encode.sv
design/bwrle_outq.sv
design/bw_boolean_combine_rle_encoder.sv
design/bwrle_checker.sv
bench/bw_boolean_combine_rle_encoder_tb.sv
